[rtl/rtdc_pkg.sv]
// shared constants, breakpoint tables and helpers for the rtd code to temperature unit
package rtdc_pkg;

    localparam int CODE_W    = 13;
    localparam int TEMP_W    = 11;
    localparam int TAB_LEN   = 18;
    localparam int IDX_W     = 5;
    localparam int OFF_W     = 7;
    localparam int SLOPE_W   = 18;
    localparam int PROD_W    = SLOPE_W + OFF_W;
    localparam int FRAC_BITS = 16;
    localparam int MUL_CNT_W = 3;

    typedef logic [CODE_W-1:0]  code_t;
    typedef logic [TEMP_W-1:0]  temp_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [OFF_W-1:0]   off_t;
    typedef logic [SLOPE_W-1:0] slope_t;
    typedef logic [PROD_W-1:0]  prod_t;

    localparam idx_t  FIRST_IDX = IDX_W'(1);
    localparam idx_t  LAST_IDX  = IDX_W'(TAB_LEN - 1);
    localparam temp_t TEMP_STEP = TEMP_W'(100);
    localparam temp_t TEMP_MIN  = TEMP_W'(0);
    localparam temp_t TEMP_MAX  = TEMP_W'(1700);

    // breakpoint codes, floor(8192*r/(r+1000))
    localparam code_t CODE_TAB [0:TAB_LEN-1] = '{
        13'd4096, 13'd4174, 13'd4249, 13'd4322, 13'd4390, 13'd4458,
        13'd4521, 13'd4584, 13'd4644, 13'd4701, 13'd4757, 13'd4811,
        13'd4863, 13'd4912, 13'd4961, 13'd5008, 13'd5054, 13'd5098
    };

    // (100 << 16) / (code[i] - code[i-1]), entry i for the segment ending at i
    localparam slope_t SLOPE_TAB [0:TAB_LEN-1] = '{
        18'd0,      18'd84020,  18'd87381,  18'd89775,  18'd96376,  18'd96376,
        18'd104025, 18'd104025, 18'd109226, 18'd114975, 18'd117028, 18'd121362,
        18'd126030, 18'd133746, 18'd133746, 18'd139438, 18'd142469, 18'd148945
    };

    // temperature of the breakpoint below segment idx
    function automatic temp_t base_temp(input idx_t idx);
        idx_t seg;
        seg = idx - FIRST_IDX;
        return TEMP_W'(TEMP_W'(seg) * TEMP_STEP);
    endfunction

endpackage

[rtl/rtdc_mul.sv]
// bit-serial shift-add multiplier for segment slope times code offset
module rtdc_mul (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  rtdc_pkg::slope_t multiplicand,
    input  rtdc_pkg::off_t   multiplier,
    output logic             done,
    output rtdc_pkg::prod_t  product
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [rtdc_pkg::MUL_CNT_W-1:0] cnt_reg, cnt_next;
    rtdc_pkg::prod_t                mcand_reg, mcand_next;
    rtdc_pkg::off_t                 mplier_reg, mplier_next;
    rtdc_pkg::prod_t                acc_reg, acc_next;

    localparam logic [rtdc_pkg::MUL_CNT_W-1:0] LAST_CNT =
        rtdc_pkg::MUL_CNT_W'(rtdc_pkg::OFF_W - 1);

    always_comb begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        if (start) begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            mcand_next  = rtdc_pkg::PROD_W'(multiplicand);
            mplier_next = multiplier;
            acc_next    = '0;
        end else if (busy_reg) begin
            // one multiplier bit per cycle, lsb first
            if (mplier_reg[0]) begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == LAST_CNT) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

[rtl/rtd_code_to_temperature_unit.sv]
// top level: pt1000 divider code to temperature by piecewise linear interpolation
//
// Takes one 13-bit divider code per word and returns the temperature in tenths of a
// degree C, clamped to 0 at or below the first breakpoint and to 1700 at or above the
// last. One word is worked on at a time. A clamped code goes straight to the done state;
// an interpolated code passes the table scan (one breakpoint per cycle, its length set
// by the segment the code falls in) and the bit-serial slope multiplier. Either result
// waits until the output register is free. The next word is accepted as soon as the
// current one reaches the output register, even if that result is not yet taken.
module rtd_code_to_temperature_unit (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  rtdc_pkg::code_t s_adc_code,
    output logic            m_valid,
    input  logic            m_ready,
    output rtdc_pkg::temp_t m_temperature
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic               m_valid_reg, m_valid_next;
    rtdc_pkg::code_t    code_reg, code_next;
    rtdc_pkg::idx_t     idx_reg, idx_next;
    rtdc_pkg::temp_t    base_reg, base_next;
    rtdc_pkg::off_t     off_reg, off_next;
    rtdc_pkg::slope_t   slope_reg, slope_next;
    rtdc_pkg::temp_t    temp_reg, temp_next;
    rtdc_pkg::temp_t    out_reg, out_next;

    logic               accept;
    logic               found;
    logic               out_load;
    logic               mul_start;
    logic               mul_done;
    rtdc_pkg::prod_t    mul_product;
    rtdc_pkg::idx_t     prev_idx;
    rtdc_pkg::code_t    off_full;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign prev_idx = idx_reg - rtdc_pkg::FIRST_IDX;
    assign found    = (idx_reg == rtdc_pkg::LAST_IDX) ||
                      (rtdc_pkg::CODE_TAB[idx_reg] > code_reg);
    assign off_full = code_reg - rtdc_pkg::CODE_TAB[prev_idx];
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    assign mul_start = (state_reg == ST_SCAN) && found;

    rtdc_mul u_mul (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (mul_start),
        .multiplicand (slope_next),
        .multiplier   (off_next),
        .done         (mul_done),
        .product      (mul_product)
    );

    always_comb begin
        state_next = state_reg;
        code_next  = code_reg;
        idx_next   = idx_reg;
        base_next  = base_reg;
        off_next   = off_reg;
        slope_next = slope_reg;
        temp_next  = temp_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    code_next = s_adc_code;
                    idx_next  = rtdc_pkg::FIRST_IDX;
                    if (s_adc_code <= rtdc_pkg::CODE_TAB[0]) begin
                        temp_next  = rtdc_pkg::TEMP_MIN;
                        state_next = ST_DONE;
                    end else if (s_adc_code >= rtdc_pkg::CODE_TAB[rtdc_pkg::TAB_LEN-1]) begin
                        temp_next  = rtdc_pkg::TEMP_MAX;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (found) begin
                    base_next  = rtdc_pkg::base_temp(idx_reg);
                    off_next   = off_full[rtdc_pkg::OFF_W-1:0];
                    slope_next = rtdc_pkg::SLOPE_TAB[idx_reg];
                    state_next = ST_MUL;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    temp_next  = base_reg + rtdc_pkg::TEMP_W'(
                        mul_product[rtdc_pkg::FRAC_BITS +: rtdc_pkg::OFF_W]);
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            out_next     = temp_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg  <= code_next;
        idx_reg   <= idx_next;
        base_reg  <= base_next;
        off_reg   <= off_next;
        slope_reg <= slope_next;
        temp_reg  <= temp_next;
        out_reg   <= out_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_temperature = out_reg;

endmodule
